/* rtl/lds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and codes of the layer dependency scheduler.
// ----------------------------------------------------------------------------
package lds_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_PREPARE = 3'd1;
  localparam logic [2:0] CMD_EXEC    = 3'd2;
  localparam logic [2:0] CMD_RERUN   = 3'd3;
  localparam logic [2:0] CMD_MARK    = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  // dependency types
  localparam logic [1:0] DEP_NONE = 2'd0;
  localparam logic [1:0] DEP_SEQ  = 2'd1;

  // operating modes that free dead outputs
  localparam logic [1:0] MODE_MEM   = 2'd1;
  localparam logic [1:0] MODE_ADAPT = 2'd2;

  // entry flag bit positions
  localparam int FL_EXEC = 0;
  localparam int FL_NEED = 1;
  localparam int FL_HELD = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] layer_id;
    logic [1:0]  dep_type;
    logic [7:0]  depends_on;
    logic [31:0] output_size;
    logic [7:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] issued_layer;
    logic [7:0]  issued_entry;
    logic        is_final;
    logic        entry_executed;
    logic [39:0] usage_now;
    logic [39:0] usage_peak;
  } out_item_t;

  typedef enum logic [2:0] {
    FW_NONE, FW_ADD, FW_NEED, FW_RERUN, FW_ALLOC, FW_MARK, FW_REL
  } flags_op_t;

  typedef enum logic [2:0] {
    H_NONE, H_ZERO, H_ADD, H_SUB_MARK, H_SUB_REL
  } held_op_t;

  typedef enum logic [1:0] {P_NONE, P_ZERO, P_HELD, P_MAX} peak_op_t;

  typedef enum logic [1:0] {L_NONE, L_CLR, L_MARK} live_op_t;

  typedef enum logic [1:0] {RES_FAIL, RES_PLAIN, RES_ISSUE, RES_QUERY} res_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_ld;
    logic      cnt_inc;
    logic      meta_we;
    logic      prev_clr;
    logic      prev_ld;
    logic      iss_ld;
    logic      res_load;
    flags_op_t flags_op;
    held_op_t  held_op;
    peak_op_t  peak_op;
    live_op_t  live_op;
    res_kind_t res_kind;
  } lds_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       add_bad;
    logic       idx_bad;
    logic       cnt_zero;
    logic       idx_last;
    logic       hit;
    logic       free_mode;
    logic       out_busy;
  } lds_stat_t;

endpackage
`default_nettype wire

/* rtl/lds_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lds_chan_if
// Valid/ready channel carrying one beat of type T.
// ----------------------------------------------------------------------------
interface lds_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lds_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lds_dp
// Entry tables, flag and liveness memories, byte counters, result register.
// ----------------------------------------------------------------------------
module lds_dp import lds_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int SIZE_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_wdata,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  lds_cmd_t  cmd_i,
  output lds_stat_t stat_o
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int SZW  = (SIZE_BITS < 32) ? SIZE_BITS : 32;
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef struct packed {
    logic [15:0]    layer;
    logic [1:0]     dep;
    logic [7:0]     target;
    logic [SZW-1:0] size;
  } meta_t;

  meta_t     meta_mem [MAX_ENTRIES];
  logic [2:0] flags_mem [MAX_ENTRIES];
  logic      live_mem [MAX_ENTRIES];

  logic [1:0]  mode_r;
  in_item_t    req_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [39:0] held_r;
  logic [39:0] peak_r;
  logic        prev_exec_r;
  meta_t       meta_q;
  logic [2:0]  fa_q;
  logic [2:0]  fb_q;
  logic        live_q;
  logic [15:0] iss_layer_r;
  logic [7:0]  iss_entry_r;
  logic        iss_final_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] tgt_addr;
  logic [IW-1:0] prev_addr;
  logic [CW-1:0] idx_m1;
  logic          rel_cond;
  logic          fl_we;
  logic [IW-1:0] fl_addr;
  logic [2:0]    fl_wdata;
  logic          lv_we;
  logic [IW-1:0] lv_addr;
  logic          lv_wdata;
  logic [39:0]   held_sum;
  logic [39:0]   held_dif;

  assign rd_addr   = idx_r[IW-1:0];
  assign tgt_addr  = IW'(meta_q.target);
  assign idx_m1    = idx_r - CW'(1);
  assign prev_addr = idx_m1[IW-1:0];
  assign rel_cond  = fa_q[FL_EXEC] && fa_q[FL_NEED] && !live_q;
  assign held_sum  = held_r + 40'(meta_q.size);
  assign held_dif  = held_r - 40'(meta_q.size);

  // flag write port
  always_comb begin
    fl_we    = 1'b0;
    fl_addr  = rd_addr;
    fl_wdata = fa_q;
    unique case (cmd_i.flags_op)
      FW_NONE: ;
      FW_ADD: begin
        fl_we    = 1'b1;
        fl_addr  = cnt_r[IW-1:0];
        fl_wdata = 3'b000;
        fl_wdata[FL_NEED] = 1'b1;
      end
      FW_NEED: begin
        fl_we    = 1'b1;
        fl_wdata = 3'b000;
        fl_wdata[FL_NEED] = 1'b1;
      end
      FW_RERUN: begin
        fl_we    = 1'b1;
        fl_wdata = 3'b000;
        fl_wdata[FL_HELD] = fa_q[FL_HELD];
        fl_wdata[FL_NEED] = 1'b1;
      end
      FW_ALLOC: begin
        fl_we = 1'b1;
        fl_wdata[FL_EXEC] = 1'b1;
        if (meta_q.size != '0) begin
          fl_wdata[FL_HELD] = 1'b1;
        end
      end
      FW_MARK: begin
        fl_we = 1'b1;
        fl_wdata[FL_HELD] = 1'b0;
        fl_wdata[FL_NEED] = 1'b0;
      end
      FW_REL: begin
        fl_we = rel_cond;
        fl_wdata[FL_HELD] = 1'b0;
        fl_wdata[FL_NEED] = 1'b0;
      end
      default: ;
    endcase
  end

  // liveness write port
  always_comb begin
    lv_we    = 1'b0;
    lv_addr  = rd_addr;
    lv_wdata = 1'b0;
    unique case (cmd_i.live_op)
      L_NONE: ;
      L_CLR: lv_we = 1'b1;
      L_MARK: begin
        lv_wdata = 1'b1;
        if (!fa_q[FL_EXEC]) begin
          if (meta_q.dep[1]) begin
            lv_we   = 1'b1;
            lv_addr = tgt_addr;
          end else if (meta_q.dep == DEP_SEQ && idx_r != '0) begin
            lv_we   = 1'b1;
            lv_addr = prev_addr;
          end
        end
      end
      default: ;
    endcase
  end

  // result beat contents
  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.usage_now  = held_r;
    out_data_nxt.usage_peak = peak_r;
    unique case (cmd_i.res_kind)
      RES_FAIL:  out_data_nxt.status = 1'b1;
      RES_PLAIN: ;
      RES_ISSUE: begin
        out_data_nxt.issued_layer = iss_layer_r;
        out_data_nxt.issued_entry = iss_entry_r;
        out_data_nxt.is_final     = iss_final_r;
      end
      RES_QUERY: out_data_nxt.entry_executed = fa_q[FL_EXEC];
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd_i.meta_we) begin
      meta_mem[cnt_r[IW-1:0]] <= '{layer:  req_r.layer_id,
                                   dep:    req_r.dep_type,
                                   target: req_r.depends_on,
                                   size:   SZW'(req_r.output_size)};
    end
    if (fl_we) begin
      flags_mem[fl_addr] <= fl_wdata;
    end
    if (lv_we) begin
      live_mem[lv_addr] <= lv_wdata;
    end
    meta_q <= meta_mem[rd_addr];
    fa_q   <= flags_mem[rd_addr];
    fb_q   <= flags_mem[tgt_addr];
    live_q <= live_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      req_r <= in_data;
    end
    if (cmd_i.iss_ld) begin
      iss_layer_r <= meta_q.layer;
      iss_entry_r <= 8'(idx_r);
      iss_final_r <= stat_o.idx_last;
    end
    if (cmd_i.res_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      held_r      <= '0;
      peak_r      <= '0;
      prev_exec_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (cmd_i.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_r <= '0;
      end else if (cmd_i.idx_ld) begin
        idx_r <= CW'(req_r.entry_index);
      end else if (cmd_i.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd_i.prev_clr) begin
        prev_exec_r <= 1'b0;
      end else if (cmd_i.prev_ld) begin
        prev_exec_r <= fa_q[FL_EXEC];
      end
      unique case (cmd_i.held_op)
        H_NONE: ;
        H_ZERO: held_r <= '0;
        H_ADD: begin
          if (!fa_q[FL_HELD] && meta_q.size != '0) begin
            held_r <= held_sum;
          end
        end
        H_SUB_MARK: begin
          if (fa_q[FL_HELD]) begin
            held_r <= held_dif;
          end
        end
        H_SUB_REL: begin
          if (rel_cond && fa_q[FL_HELD]) begin
            held_r <= held_dif;
          end
        end
        default: ;
      endcase
      unique case (cmd_i.peak_op)
        P_NONE: ;
        P_ZERO: peak_r <= '0;
        P_HELD: peak_r <= held_r;
        P_MAX: begin
          if (held_r > peak_r) begin
            peak_r <= held_r;
          end
        end
        default: ;
      endcase
      if (cmd_i.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat_o.cmd       = req_r.cmd;
    stat_o.full      = (cnt_r == CW'(MAX_ENTRIES));
    stat_o.add_bad   = req_r.dep_type[1] && (CMPW'(req_r.depends_on) >= CMPW'(cnt_r));
    stat_o.idx_bad   = CMPW'(req_r.entry_index) >= CMPW'(cnt_r);
    stat_o.cnt_zero  = (cnt_r == '0);
    stat_o.idx_last  = ((idx_r + CW'(1)) == cnt_r);
    stat_o.hit       = !fa_q[FL_EXEC] &&
                       ((meta_q.dep == DEP_NONE) ||
                        (meta_q.dep == DEP_SEQ && (idx_r == '0 || prev_exec_r)) ||
                        (meta_q.dep[1] && fb_q[FL_EXEC]));
    stat_o.free_mode = (mode_r == MODE_MEM) || (mode_r == MODE_ADAPT);
    stat_o.out_busy  = out_valid_r && !out_ready;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> cnt_r == $past(cnt_r) + CW'(1))
    else $error("entry count moved by more than one");

  a_peak_max: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(cmd_i.peak_op == P_MAX)) |-> peak_r >= held_r)
    else $error("peak below usage after peak update");

endmodule
`default_nettype wire

/* rtl/lds_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lds_ctrl
// Command sequencer: decodes a beat and steps the datapath through scans.
// ----------------------------------------------------------------------------
module lds_ctrl import lds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lds_stat_t stat_i,
  output lds_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_PREP_W, S_RR_RD, S_RR_WR,
    S_SC_RD, S_SC_T, S_SC_CHK, S_AL_ADD, S_AL_PEAK,
    S_LC, S_LM_RD, S_LM_WR, S_RL_RD, S_RL_WR,
    S_MK_RD, S_MK_WR, S_Q_RD, S_RES
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= RES_PLAIN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.flags_op = FW_NONE;
    cmd_o.held_op  = H_NONE;
    cmd_o.peak_op  = P_NONE;
    cmd_o.live_op  = L_NONE;
    cmd_o.res_kind = kind_r;
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_RES;
        kind_nxt  = RES_PLAIN;
        unique case (stat_i.cmd)
          CMD_ADD: begin
            if (stat_i.full || stat_i.add_bad) begin
              kind_nxt = RES_FAIL;
            end else begin
              cmd_o.meta_we  = 1'b1;
              cmd_o.flags_op = FW_ADD;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          CMD_PREPARE: begin
            cmd_o.held_op = H_ZERO;
            cmd_o.peak_op = P_ZERO;
            cmd_o.idx_clr = 1'b1;
            if (!stat_i.cnt_zero) begin
              state_nxt = S_PREP_W;
            end
          end
          CMD_EXEC: begin
            cmd_o.idx_clr  = 1'b1;
            cmd_o.prev_clr = 1'b1;
            if (stat_i.cnt_zero) begin
              kind_nxt = RES_FAIL;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
          CMD_RERUN: begin
            cmd_o.peak_op = P_HELD;
            cmd_o.idx_clr = 1'b1;
            if (!stat_i.cnt_zero) begin
              state_nxt = S_RR_RD;
            end
          end
          CMD_MARK: begin
            if (stat_i.idx_bad) begin
              kind_nxt = RES_FAIL;
            end else begin
              cmd_o.idx_ld = 1'b1;
              state_nxt    = S_MK_RD;
            end
          end
          CMD_QUERY: begin
            if (stat_i.idx_bad) begin
              kind_nxt = RES_FAIL;
            end else begin
              cmd_o.idx_ld = 1'b1;
              state_nxt    = S_Q_RD;
            end
          end
          default: kind_nxt = RES_FAIL;
        endcase
      end
      S_PREP_W: begin
        cmd_o.flags_op = FW_NEED;
        cmd_o.idx_inc  = 1'b1;
        if (stat_i.idx_last) begin
          state_nxt = S_RES;
        end
      end
      S_RR_RD: state_nxt = S_RR_WR;
      S_RR_WR: begin
        cmd_o.flags_op = FW_RERUN;
        cmd_o.idx_inc  = 1'b1;
        state_nxt      = stat_i.idx_last ? S_RES : S_RR_RD;
      end
      S_SC_RD: state_nxt = S_SC_T;
      S_SC_T:  state_nxt = S_SC_CHK;
      S_SC_CHK: begin
        if (stat_i.hit) begin
          state_nxt = S_AL_ADD;
        end else begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (stat_i.idx_last) begin
            kind_nxt  = RES_FAIL;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_AL_ADD: begin
        cmd_o.held_op  = H_ADD;
        cmd_o.flags_op = FW_ALLOC;
        cmd_o.iss_ld   = 1'b1;
        state_nxt      = S_AL_PEAK;
      end
      S_AL_PEAK: begin
        cmd_o.peak_op = P_MAX;
        kind_nxt      = RES_ISSUE;
        if (stat_i.free_mode) begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = S_LC;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_LC: begin
        cmd_o.live_op = L_CLR;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = S_LM_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_LM_RD: state_nxt = S_LM_WR;
      S_LM_WR: begin
        cmd_o.live_op = L_MARK;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = S_RL_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = S_LM_RD;
        end
      end
      S_RL_RD: state_nxt = S_RL_WR;
      S_RL_WR: begin
        cmd_o.flags_op = FW_REL;
        cmd_o.held_op  = H_SUB_REL;
        cmd_o.idx_inc  = 1'b1;
        state_nxt      = stat_i.idx_last ? S_RES : S_RL_RD;
      end
      S_MK_RD: state_nxt = S_MK_WR;
      S_MK_WR: begin
        cmd_o.flags_op = FW_MARK;
        cmd_o.held_op  = H_SUB_MARK;
        state_nxt      = S_RES;
      end
      S_Q_RD: begin
        kind_nxt  = RES_QUERY;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/layer_dependency_scheduler_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// layer_dependency_scheduler_core
// Layer table scheduler with dependency check and output buffer liveness.
// ----------------------------------------------------------------------------
// Prepare and rerun each sweep all entries in the table; add, mark, query
// and unknown codes need no sweep. Execute scans from entry 0 until it finds
// an entry to issue and, in the freeing modes, adds a clear, a mark and a
// release sweep over the liveness and flag memories.
// One command is in flight at a time; the next beat is taken when the
// sequencer returns to idle, while the result register may still be held.
// Reset (rst_n low, synchronous) empties the table, zeroes both byte
// counters and mode; no clearing pass is needed since the table is read
// only below the entry count.
// ----------------------------------------------------------------------------
module layer_dependency_scheduler_core import lds_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int SIZE_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  lds_chan_if.sink   in_chan,
  lds_chan_if.source out_chan
);

  lds_cmd_t  cmd;
  lds_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // sequencer: decode the beat, step the scans, hold until the result drains
  lds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // datapath: tables, counters and the result register
  lds_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

endmodule
`default_nettype wire
